// ===== design/ciau_pkg.sv =====
// shared types, codes and helpers for the checked integer alu
// no dependencies
`default_nettype none
package ciau_pkg;

    typedef enum logic [4:0] {
        CMD_PLUS = 5'd0, CMD_NEG = 5'd1, CMD_LNOT = 5'd2, CMD_BNOT = 5'd3,
        CMD_ADD = 5'd4, CMD_SUB = 5'd5, CMD_MUL = 5'd6, CMD_DIV = 5'd7,
        CMD_MOD = 5'd8, CMD_LT = 5'd9, CMD_GT = 5'd10, CMD_LE = 5'd11,
        CMD_GE = 5'd12, CMD_EQ = 5'd13, CMD_NE = 5'd14, CMD_LAND = 5'd15,
        CMD_LOR = 5'd16, CMD_AND = 5'd17, CMD_OR = 5'd18, CMD_XOR = 5'd19,
        CMD_SHL = 5'd20, CMD_SHR = 5'd21, CMD_CAST = 5'd22
    } cmd_t;

    localparam logic [3:0] UB_NONE = 4'd0;
    localparam logic [3:0] UB_UNINIT = 4'd1;
    localparam logic [3:0] UB_SOVF = 4'd2;
    localparam logic [3:0] UB_MINNEG = 4'd3;
    localparam logic [3:0] UB_ZDIV = 4'd4;
    localparam logic [3:0] UB_SHNEG = 4'd5;
    localparam logic [3:0] UB_SHBIG = 4'd6;
    localparam logic [3:0] UB_NEGSH = 4'd7;
    localparam logic [3:0] UB_TYPE = 4'd8;
    localparam logic [3:0] TY_BOOL = 4'd0;
    localparam logic [3:0] TY_MAX = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_DONE
    } state_t;

    // start request to the shared shift-add unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] x;
        logic [63:0] y;
    } unit_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
        logic [63:0]  quo;
        logic [63:0]  rem;
    } unit_rsp_t;

    function automatic logic [6:0] type_width(input logic [3:0] t);
        case (t)
            4'd0: type_width = 7'd1;
            4'd1, 4'd2: type_width = 7'd8;
            4'd3, 4'd4: type_width = 7'd16;
            4'd5, 4'd6: type_width = 7'd32;
            default: type_width = 7'd64;
        endcase
    endfunction

    function automatic logic [6:0] shift_size(input logic [3:0] t);
        shift_size = (t == TY_BOOL) ? 7'd8 : type_width(t);
    endfunction

    function automatic logic type_signed(input logic [3:0] t);
        type_signed = (t == 4'd1) || (t == 4'd3) || (t == 4'd5) || (t == 4'd7);
    endfunction

    function automatic logic [63:0] mask_w(input logic [6:0] w);
        mask_w = (w >= 7'd64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w[5:0]) - 64'd1);
    endfunction

    // canonical 64-bit form of a typed value
    function automatic logic [63:0] canon(input logic [3:0] t, input logic [63:0] v);
        logic [6:0]  w;
        logic [63:0] m;
        logic [63:0] r;
        w = type_width(t);
        m = mask_w(w);
        r = v & m;
        if (type_signed(t) && w < 7'd64 && r[w[5:0] - 6'd1])
            r = r | ~m;
        canon = r;
    endfunction

    // convert a 64-bit value to type t
    function automatic logic [63:0] fit(input logic [3:0] t, input logic [63:0] v);
        if (t == TY_BOOL)
            fit = {63'd0, v != 64'd0};
        else
            fit = v & mask_w(type_width(t));
    endfunction

endpackage
`default_nettype wire

// ===== design/ciau_unit.sv =====
// shared shift-add unit: 64x64 multiply or 64/64 restoring divide, one bit a cycle
// depends on ciau_pkg
`default_nettype none
module ciau_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ciau_pkg::unit_req_t req,
    output ciau_pkg::unit_rsp_t      rsp
);
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         div_reg, div_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  y_reg, y_next;
    logic [64:0]  trial;
    logic [64:0]  msum;

    // one step of multiply or divide
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next = div_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        y_next = y_reg;
        trial = {acc_reg[127:63]} - {1'b0, y_reg};
        msum = {1'b0, acc_reg[127:64]} + (acc_reg[0] ? {1'b0, y_reg} : 65'd0);
        if (req.start) begin
            busy_next = 1'b1;
            div_next = req.is_div;
            cnt_next = 7'd0;
            y_next = req.y;
            acc_next = {64'd0, req.x};
        end else if (busy_reg) begin
            if (div_reg) begin
                // acc high holds remainder, low shifts dividend out
                if (!trial[64]) begin
                    acc_next = {trial[63:0], acc_reg[62:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[126:0], 1'b0};
                end
            end else begin
                // multiplier bits leave at the bottom, y added into the high half
                acc_next = {msum, acc_reg[63:1]};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        y_reg <= y_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quo = acc_reg[63:0];
    assign rsp.rem = acc_reg[127:64];
endmodule
`default_nettype wire

// ===== design/checked_integer_alu_ub_detect_core.sv =====
// top level of the checked integer alu: decode, checks, sequencer, result register
// depends on ciau_pkg and ciau_unit
// result registered on the input transfer for fast operations; mul, div and mod that reach
// the shared shift-add unit pass through ST_MUL or ST_DIV, its 64 one-bit steps, then ST_FIX
// the next input is taken only after the result transfer, so one item at a time
// reset is synchronous: active-low aresetn clears the sequencer and output valid, sets lang_reg to 1.
`default_nettype none
module checked_integer_alu_ub_detect_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[4:0], a_type[8:5], a_value[72:9], a_ub[76:73], b_type[80:77],
    // b_value[144:81], b_ub[148:145], zero fill up to 151
    input  wire logic [151:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_type[3:0], res_value[67:4], res_ub[71:68]
    output logic [71:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data
);
    ciau_pkg::state_t    state_reg, state_next;
    ciau_pkg::unit_req_t req;
    ciau_pkg::unit_rsp_t rsp;

    logic        lang_reg;
    logic [4:0]  cmd_reg;
    logic [3:0]  at_reg;
    logic [63:0] a_reg, b_reg;
    logic        sg_reg, neg_reg, adiv_reg;
    logic [3:0]  rt_reg, rt_next;
    logic [63:0] rv_reg, rv_next;
    logic [3:0]  ru_reg, ru_next;
    logic        ov_reg, ov_next;

    // decoded input fields
    logic [4:0]  in_cmd;
    logic [3:0]  in_at, in_aub, in_bt, in_bub;
    logic [63:0] a, b, minv, q, ma, mb;
    logic [6:0]  w;
    logic        sg;
    logic        fast_done;
    logic        go_mul, go_div;
    logic [6:0]  sigb;
    logic [6:0]  room;

    assign in_cmd = s_tdata[4:0];
    assign in_at = s_tdata[8:5];
    assign in_aub = s_tdata[76:73];
    assign in_bt = s_tdata[80:77];
    assign in_bub = s_tdata[148:145];
    assign a = ciau_pkg::canon(in_at, s_tdata[72:9]);
    assign b = ciau_pkg::canon(in_bt, s_tdata[144:81]);
    assign w = ciau_pkg::type_width(in_at);
    assign sg = ciau_pkg::type_signed(in_at);
    assign minv = ciau_pkg::canon(in_at, 64'd1 << (w[5:0] - 6'd1));
    assign ma = a[63] ? (64'd0 - a) : a;
    assign mb = b[63] ? (64'd0 - b) : b;

    // significant bits of a (position of leading one)
    always_comb begin
        sigb = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (a[i]) sigb = 7'(i + 1);
        end
    end
    assign room = w - sigb;

    assign s_tready = (state_reg == ciau_pkg::ST_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = ov_reg;
    assign m_tdata = {ru_reg, (ru_reg != ciau_pkg::UB_NONE) ? 64'd0 : rv_reg, rt_reg};

    // decode, checks and fast operations
    always_comb begin
        fast_done = 1'b1;
        go_mul = 1'b0;
        go_div = 1'b0;
        rt_next = in_at;
        rv_next = 64'd0;
        ru_next = ciau_pkg::UB_NONE;
        q = 64'd0;
        if (in_cmd > ciau_pkg::CMD_CAST || in_at > ciau_pkg::TY_MAX) begin
            rt_next = ciau_pkg::TY_BOOL;
            ru_next = ciau_pkg::UB_TYPE;
        end else if (in_cmd <= ciau_pkg::CMD_BNOT) begin
            if (in_cmd == ciau_pkg::CMD_LNOT && in_at != ciau_pkg::TY_BOOL) begin
                rt_next = ciau_pkg::TY_BOOL;
                ru_next = ciau_pkg::UB_TYPE;
            end else if (in_aub != 4'd0) begin
                ru_next = (in_cmd == ciau_pkg::CMD_PLUS && in_aub <= 4'd8) ?
                          in_aub : ciau_pkg::UB_UNINIT;
            end else begin
                case (ciau_pkg::cmd_t'(in_cmd))
                    ciau_pkg::CMD_PLUS: rv_next = ciau_pkg::fit(in_at, a);
                    ciau_pkg::CMD_NEG: begin
                        if (sg && a == minv) ru_next = ciau_pkg::UB_SOVF;
                        else rv_next = ciau_pkg::fit(in_at, 64'd0 - a);
                    end
                    ciau_pkg::CMD_LNOT: begin
                        rt_next = ciau_pkg::TY_BOOL;
                        rv_next = {63'd0, a == 64'd0};
                    end
                    default: rv_next = ciau_pkg::fit(in_at, ~a);
                endcase
            end
        end else if (in_bt > ciau_pkg::TY_MAX) begin
            rt_next = ciau_pkg::TY_BOOL;
            ru_next = ciau_pkg::UB_TYPE;
        end else if (in_cmd == ciau_pkg::CMD_CAST) begin
            rt_next = in_bt;
            if (in_aub != 4'd0) ru_next = ciau_pkg::UB_UNINIT;
            else rv_next = ciau_pkg::fit(in_bt, a);
        end else if (in_cmd == ciau_pkg::CMD_SHL || in_cmd == ciau_pkg::CMD_SHR) begin
            if (ciau_pkg::type_signed(in_bt) && b[63]) ru_next = ciau_pkg::UB_SHNEG;
            else if (b >= {57'd0, ciau_pkg::shift_size(in_at)}) ru_next = ciau_pkg::UB_SHBIG;
            else if (in_aub != 4'd0 || in_bub != 4'd0) ru_next = ciau_pkg::UB_UNINIT;
            else if (sg && a[63]) ru_next = ciau_pkg::UB_NEGSH;
            else if (in_cmd == ciau_pkg::CMD_SHR)
                rv_next = ciau_pkg::fit(in_at, a >> b[5:0]);
            else if (sg && (lang_reg ? (b[6:0] >= room) : (b[6:0] > room)))
                ru_next = ciau_pkg::UB_SHBIG;
            else rv_next = ciau_pkg::fit(in_at, a << b[5:0]);
        end else if (in_bt != in_at ||
                     ((in_cmd == ciau_pkg::CMD_LAND || in_cmd == ciau_pkg::CMD_LOR) &&
                      in_at != ciau_pkg::TY_BOOL)) begin
            rt_next = ciau_pkg::TY_BOOL;
            ru_next = ciau_pkg::UB_TYPE;
        end else begin
            if (in_cmd >= ciau_pkg::CMD_LT && in_cmd <= ciau_pkg::CMD_LOR)
                rt_next = ciau_pkg::TY_BOOL;
            if (in_aub != 4'd0 || in_bub != 4'd0) begin
                ru_next = ciau_pkg::UB_UNINIT;
            end else begin
                case (ciau_pkg::cmd_t'(in_cmd))
                    ciau_pkg::CMD_ADD: begin
                        q = a + b;
                        if (sg && ((((a ^ q) & (b ^ q)) >> 63) != 64'd0 ||
                                   ciau_pkg::canon(in_at, q) != q))
                            ru_next = ciau_pkg::UB_SOVF;
                        else rv_next = ciau_pkg::fit(in_at, q);
                    end
                    ciau_pkg::CMD_SUB: begin
                        q = a - b;
                        if (sg && ((((a ^ b) & (a ^ q)) >> 63) != 64'd0 ||
                                   ciau_pkg::canon(in_at, q) != q))
                            ru_next = ciau_pkg::UB_SOVF;
                        else rv_next = ciau_pkg::fit(in_at, q);
                    end
                    ciau_pkg::CMD_MUL: begin
                        if (sg && ((a == minv && b == '1) || (b == minv && a == '1)))
                            ru_next = ciau_pkg::UB_MINNEG;
                        else begin
                            fast_done = 1'b0;
                            go_mul = 1'b1;
                        end
                    end
                    ciau_pkg::CMD_DIV, ciau_pkg::CMD_MOD: begin
                        if (b == 64'd0) ru_next = ciau_pkg::UB_ZDIV;
                        else if (sg && ((a == minv && b == '1) || (b == minv && a == '1)))
                            ru_next = ciau_pkg::UB_SOVF;
                        else begin
                            fast_done = 1'b0;
                            go_div = 1'b1;
                        end
                    end
                    ciau_pkg::CMD_LT: rv_next = {63'd0, sg ? ($signed(a) < $signed(b)) : (a < b)};
                    ciau_pkg::CMD_GT: rv_next = {63'd0, sg ? ($signed(b) < $signed(a)) : (b < a)};
                    ciau_pkg::CMD_LE: rv_next = {63'd0, sg ? !($signed(b) < $signed(a)) : !(b < a)};
                    ciau_pkg::CMD_GE: rv_next = {63'd0, sg ? !($signed(a) < $signed(b)) : !(a < b)};
                    ciau_pkg::CMD_EQ: rv_next = {63'd0, a == b};
                    ciau_pkg::CMD_NE: rv_next = {63'd0, a != b};
                    ciau_pkg::CMD_LAND: rv_next = {63'd0, (a != 64'd0) && (b != 64'd0)};
                    ciau_pkg::CMD_LOR: rv_next = {63'd0, (a != 64'd0) || (b != 64'd0)};
                    ciau_pkg::CMD_AND: rv_next = ciau_pkg::fit(in_at, a & b);
                    ciau_pkg::CMD_OR: rv_next = ciau_pkg::fit(in_at, a | b);
                    default: rv_next = ciau_pkg::fit(in_at, a ^ b);
                endcase
            end
        end
    end

    // unit start request
    always_comb begin
        req.start = s_tvalid && s_tready && (go_mul || go_div);
        req.is_div = go_div;
        req.x = sg ? ma : a;
        req.y = sg ? mb : b;
    end

    ciau_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // product, quotient and remainder fixup values
    logic [63:0]  lim;
    logic [63:0]  sq, sr;
    logic [127:0] p;
    assign p = rsp.prod;
    assign lim = (64'd1 << (ciau_pkg::type_width(at_reg) - 7'd1)) - (neg_reg ? 64'd0 : 64'd1);
    assign sq = ((a_reg ^ b_reg) >> 63) != 64'd0 ? 64'd0 - rsp.quo : rsp.quo;
    assign sr = a_reg[63] ? 64'd0 - rsp.rem : rsp.rem;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ciau_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready && !fast_done)
                    state_next = go_div ? ciau_pkg::ST_DIV : ciau_pkg::ST_MUL;
            end
            ciau_pkg::ST_MUL, ciau_pkg::ST_DIV: begin
                if (rsp.done) state_next = ciau_pkg::ST_FIX;
            end
            ciau_pkg::ST_FIX: state_next = ciau_pkg::ST_DONE;
            ciau_pkg::ST_DONE: state_next = ciau_pkg::ST_IDLE;
            default: state_next = ciau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ciau_pkg::ST_IDLE;
            ov_reg <= 1'b0;
            lang_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) lang_reg <= cfg_data;
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            if (s_tvalid && s_tready && fast_done) ov_reg <= 1'b1;
            if (state_reg == ciau_pkg::ST_FIX) ov_reg <= 1'b1;
        end
        // capture on input transfer
        if (s_tvalid && s_tready) begin
            cmd_reg <= in_cmd;
            at_reg <= in_at;
            a_reg <= a;
            b_reg <= b;
            sg_reg <= sg;
            neg_reg <= (ma != 64'd0) && (mb != 64'd0) && (a[63] ^ b[63]);
            adiv_reg <= go_div;
            rt_reg <= rt_next;
            rv_reg <= rv_next;
            ru_reg <= ru_next;
        end
        // result from the shared unit
        if (state_reg == ciau_pkg::ST_FIX) begin
            rt_reg <= at_reg;
            ru_reg <= ciau_pkg::UB_NONE;
            if (adiv_reg) begin
                if (sg_reg)
                    rv_reg <= ciau_pkg::fit(at_reg, (cmd_reg == ciau_pkg::CMD_DIV) ? sq : sr);
                else
                    rv_reg <= ciau_pkg::fit(at_reg, (cmd_reg == ciau_pkg::CMD_DIV) ?
                                            rsp.quo : rsp.rem);
            end else begin
                if (sg_reg && (p[127:64] != 64'd0 || p[63:0] > lim))
                    ru_reg <= ciau_pkg::UB_SOVF;
                rv_reg <= ciau_pkg::fit(at_reg, sg_reg ?
                          (neg_reg ? 64'd0 - p[63:0] : p[63:0]) : p[63:0]);
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_checked_integer_alu_ub_detect_core.sv =====
// testbench for the checked integer alu: directed and random operations, scoreboard check
// depends on ciau_pkg (command, type and ub codes) and checked_integer_alu_ub_detect_core
`default_nettype none
module tb_checked_integer_alu_ub_detect_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  b_ub;
        logic [63:0] b_value;
        logic [3:0]  b_type;
        logic [3:0]  a_ub;
        logic [63:0] a_value;
        logic [3:0]  a_type;
        logic [4:0]  cmd;
    } alu_op_t;

    typedef struct packed {
        logic [3:0]  res_ub;
        logic [63:0] res_value;
        logic [3:0]  res_type;
    } alu_res_t;

    // type properties
    function automatic int unsigned ty_width(input logic [3:0] t);
        case (t)
            4'd0: return 1;
            4'd1, 4'd2: return 8;
            4'd3, 4'd4: return 16;
            4'd5, 4'd6: return 32;
            default: return 64;
        endcase
    endfunction

    function automatic bit ty_signed(input logic [3:0] t);
        return t == 4'd1 || t == 4'd3 || t == 4'd5 || t == 4'd7;
    endfunction

    function automatic logic [63:0] low_mask(input int unsigned w);
        return w >= 64 ? {64{1'b1}} : (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input int unsigned w);
        logic [63:0] r;
        r = v & low_mask(w);
        if (w < 64 && r[w-1]) r = r | ~low_mask(w);
        return r;
    endfunction

    function automatic logic [63:0] to_full(input logic [3:0] t, input logic [63:0] v);
        return ty_signed(t) ? sign_ext(v, ty_width(t)) : (v & low_mask(ty_width(t)));
    endfunction

    function automatic logic [63:0] to_type(input logic [3:0] t, input logic [63:0] v);
        if (t == ciau_pkg::TY_BOOL) return {63'd0, v != 0};
        return v & low_mask(ty_width(t));
    endfunction

    function automatic alu_res_t mk(input logic [3:0] t, input logic [63:0] v,
                                    input logic [3:0] ub);
        alu_res_t r;
        r.res_type = t;
        r.res_value = (ub != ciau_pkg::UB_NONE) ? 64'd0 : v;
        r.res_ub = ub;
        return r;
    endfunction

    function automatic bit lt_s(input logic [63:0] x, input logic [63:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] x);
        return x[63] ? -x : x;
    endfunction

    // computes the expected result of one operation
    function automatic alu_res_t alu_predict(input alu_op_t op, input bit c_rules);
        logic [63:0] a, b, minv, q, r, ma, mb, lim;
        logic [127:0] prod;
        int unsigned w, nbits, sz;
        bit sg, neg;
        logic [3:0] rt;
        if (op.cmd > ciau_pkg::CMD_CAST || op.a_type > ciau_pkg::TY_MAX)
            return mk(ciau_pkg::TY_BOOL, 64'd0, ciau_pkg::UB_TYPE);
        a = to_full(op.a_type, op.a_value);
        w = ty_width(op.a_type);
        sg = ty_signed(op.a_type);
        minv = sign_ext(64'd1 << (w - 1), w);
        if (op.cmd <= ciau_pkg::CMD_BNOT) begin
            if (op.cmd == ciau_pkg::CMD_LNOT && op.a_type != ciau_pkg::TY_BOOL)
                return mk(ciau_pkg::TY_BOOL, 64'd0, ciau_pkg::UB_TYPE);
            if (op.a_ub != 0)
                return mk(op.a_type, 64'd0,
                          (op.cmd == ciau_pkg::CMD_PLUS && op.a_ub <= 8) ?
                          op.a_ub : ciau_pkg::UB_UNINIT);
            case (op.cmd)
                ciau_pkg::CMD_PLUS:
                    return mk(op.a_type, to_type(op.a_type, a), ciau_pkg::UB_NONE);
                ciau_pkg::CMD_NEG: begin
                    if (sg && a == minv) return mk(op.a_type, 64'd0, ciau_pkg::UB_SOVF);
                    return mk(op.a_type, to_type(op.a_type, -a), ciau_pkg::UB_NONE);
                end
                ciau_pkg::CMD_LNOT:
                    return mk(ciau_pkg::TY_BOOL, {63'd0, a == 0}, ciau_pkg::UB_NONE);
                default: return mk(op.a_type, to_type(op.a_type, ~a), ciau_pkg::UB_NONE);
            endcase
        end
        if (op.b_type > ciau_pkg::TY_MAX)
            return mk(ciau_pkg::TY_BOOL, 64'd0, ciau_pkg::UB_TYPE);
        b = to_full(op.b_type, op.b_value);
        if (op.cmd == ciau_pkg::CMD_CAST) begin
            if (op.a_ub != 0) return mk(op.b_type, 64'd0, ciau_pkg::UB_UNINIT);
            return mk(op.b_type, to_type(op.b_type, a), ciau_pkg::UB_NONE);
        end
        if (op.cmd == ciau_pkg::CMD_SHL || op.cmd == ciau_pkg::CMD_SHR) begin
            sz = (op.a_type == ciau_pkg::TY_BOOL) ? 8 : w;
            if (ty_signed(op.b_type) && b[63]) return mk(op.a_type, 64'd0, ciau_pkg::UB_SHNEG);
            if (b >= sz) return mk(op.a_type, 64'd0, ciau_pkg::UB_SHBIG);
            if (op.a_ub != 0 || op.b_ub != 0) return mk(op.a_type, 64'd0, ciau_pkg::UB_UNINIT);
            if (sg && a[63]) return mk(op.a_type, 64'd0, ciau_pkg::UB_NEGSH);
            if (op.cmd == ciau_pkg::CMD_SHR)
                return mk(op.a_type, to_type(op.a_type, a >> b), ciau_pkg::UB_NONE);
            if (sg) begin
                nbits = 0;
                for (int i = 0; i < 64; i++) if (a[i]) nbits = i + 1;
                if (c_rules ? (b >= w - nbits) : (b > w - nbits))
                    return mk(op.a_type, 64'd0, ciau_pkg::UB_SHBIG);
            end
            return mk(op.a_type, to_type(op.a_type, a << b), ciau_pkg::UB_NONE);
        end
        if (op.b_type != op.a_type) return mk(ciau_pkg::TY_BOOL, 64'd0, ciau_pkg::UB_TYPE);
        if ((op.cmd == ciau_pkg::CMD_LAND || op.cmd == ciau_pkg::CMD_LOR) &&
            op.a_type != ciau_pkg::TY_BOOL)
            return mk(ciau_pkg::TY_BOOL, 64'd0, ciau_pkg::UB_TYPE);
        rt = (op.cmd >= ciau_pkg::CMD_LT && op.cmd <= ciau_pkg::CMD_LOR) ?
             ciau_pkg::TY_BOOL : op.a_type;
        if (op.a_ub != 0 || op.b_ub != 0) return mk(rt, 64'd0, ciau_pkg::UB_UNINIT);
        case (op.cmd)
            ciau_pkg::CMD_ADD: begin
                q = a + b;
                if (sg && ((((a ^ q) & (b ^ q)) >> 63) != 0 || sign_ext(q, w) != q))
                    return mk(op.a_type, 64'd0, ciau_pkg::UB_SOVF);
                return mk(op.a_type, to_type(op.a_type, q), ciau_pkg::UB_NONE);
            end
            ciau_pkg::CMD_SUB: begin
                q = a - b;
                if (sg && ((((a ^ b) & (a ^ q)) >> 63) != 0 || sign_ext(q, w) != q))
                    return mk(op.a_type, 64'd0, ciau_pkg::UB_SOVF);
                return mk(op.a_type, to_type(op.a_type, q), ciau_pkg::UB_NONE);
            end
            ciau_pkg::CMD_MUL: begin
                if (sg) begin
                    if ((a == minv && b == {64{1'b1}}) || (b == minv && a == {64{1'b1}}))
                        return mk(op.a_type, 64'd0, ciau_pkg::UB_MINNEG);
                    ma = abs64(a);
                    mb = abs64(b);
                    neg = ma != 0 && mb != 0 && (a[63] ^ b[63]);
                    lim = (64'd1 << (w - 1)) - (neg ? 64'd0 : 64'd1);
                    prod = {64'd0, ma} * {64'd0, mb};
                    if (prod > {64'd0, lim}) return mk(op.a_type, 64'd0, ciau_pkg::UB_SOVF);
                end
                return mk(op.a_type, to_type(op.a_type, a * b), ciau_pkg::UB_NONE);
            end
            ciau_pkg::CMD_DIV, ciau_pkg::CMD_MOD: begin
                if (b == 0) return mk(op.a_type, 64'd0, ciau_pkg::UB_ZDIV);
                if (!sg)
                    return mk(op.a_type,
                              to_type(op.a_type, op.cmd == ciau_pkg::CMD_DIV ? a / b : a % b),
                              ciau_pkg::UB_NONE);
                if ((a == minv && b == {64{1'b1}}) || (b == minv && a == {64{1'b1}}))
                    return mk(op.a_type, 64'd0, ciau_pkg::UB_SOVF);
                ma = abs64(a);
                mb = abs64(b);
                q = ma / mb;
                r = ma % mb;
                if (a[63] ^ b[63]) q = -q;
                if (a[63]) r = -r;
                return mk(op.a_type, to_type(op.a_type, op.cmd == ciau_pkg::CMD_DIV ? q : r),
                          ciau_pkg::UB_NONE);
            end
            ciau_pkg::CMD_LT: return mk(ciau_pkg::TY_BOOL,
                                        {63'd0, sg ? lt_s(a, b) : a < b}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_GT: return mk(ciau_pkg::TY_BOOL,
                                        {63'd0, sg ? lt_s(b, a) : b < a}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_LE: return mk(ciau_pkg::TY_BOOL,
                                        {63'd0, sg ? !lt_s(b, a) : !(b < a)}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_GE: return mk(ciau_pkg::TY_BOOL,
                                        {63'd0, sg ? !lt_s(a, b) : !(a < b)}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_EQ: return mk(ciau_pkg::TY_BOOL, {63'd0, a == b}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_NE: return mk(ciau_pkg::TY_BOOL, {63'd0, a != b}, ciau_pkg::UB_NONE);
            ciau_pkg::CMD_LAND: return mk(ciau_pkg::TY_BOOL, {63'd0, a != 0 && b != 0},
                                          ciau_pkg::UB_NONE);
            ciau_pkg::CMD_LOR: return mk(ciau_pkg::TY_BOOL, {63'd0, a != 0 || b != 0},
                                         ciau_pkg::UB_NONE);
            ciau_pkg::CMD_AND: return mk(op.a_type, to_type(op.a_type, a & b), ciau_pkg::UB_NONE);
            ciau_pkg::CMD_OR: return mk(op.a_type, to_type(op.a_type, a | b), ciau_pkg::UB_NONE);
            default: return mk(op.a_type, to_type(op.a_type, a ^ b), ciau_pkg::UB_NONE);
        endcase
    endfunction

    // holds pending results and compares them with the block output
    class alu_scoreboard;
        alu_res_t pending[$];
        bit lang_c = 1'b1;
        int errors = 0;

        function void note_op(alu_op_t op);
            pending.push_back(alu_predict(op, lang_c));
        endfunction

        function void check_res(alu_res_t got);
            alu_res_t want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.res_type !== want.res_type) begin
                $display("%0t res_type expected %0d actual %0d", $realtime,
                         want.res_type, got.res_type);
                errors++;
            end
            if (got.res_value !== want.res_value) begin
                $display("%0t res_value expected %h actual %h", $realtime,
                         want.res_value, got.res_value);
                errors++;
            end
            if (got.res_ub !== want.res_ub) begin
                $display("%0t res_ub expected %0d actual %0d", $realtime,
                         want.res_ub, got.res_ub);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [151:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    bit quiet = 1'b0;
    alu_scoreboard sb;

    always #6 aclk = ~aclk;

    checked_integer_alu_ub_detect_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // result side: random stall bursts, check on each transfer
    initial begin
        sb = new();
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_res(m_tdata);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one input transfer, with an optional gap burst ahead; valid stays up afterwards
    task automatic send_op(input alu_op_t op);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tdata <= {3'd0, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_op(op);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // register write while idle
    task automatic write_lang(input bit c_rules);
        wait_drain();
        cfg_data <= c_rules;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.lang_c = c_rules;
    endtask

    function automatic logic [63:0] edge_value();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'd1;
            2: return {64{1'b1}};
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h7FFF_FFFF_FFFF_FFFF;
            5: return {32'd0, 32'hFFFFFFFF} >> $urandom_range(0, 31);
            6: return 64'd1 << $urandom_range(0, 63);
            7: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic alu_op_t rand_op();
        alu_op_t op;
        op.cmd = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(23, 31))
                                              : 5'($urandom_range(0, 22));
        op.a_type = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        op.b_type = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 8)) : op.a_type;
        if ($urandom_range(0, 30) == 0) op.b_type = 4'($urandom_range(9, 15));
        if (op.cmd == ciau_pkg::CMD_SHL || op.cmd == ciau_pkg::CMD_SHR ||
            op.cmd == ciau_pkg::CMD_CAST)
            op.b_type = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
        op.a_value = edge_value();
        op.b_value = edge_value();
        if ((op.cmd == ciau_pkg::CMD_SHL || op.cmd == ciau_pkg::CMD_SHR) &&
            $urandom_range(0, 2) != 0)
            op.b_value = 64'($urandom_range(0, 64));
        op.a_ub = ($urandom_range(0, 10) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        op.b_ub = ($urandom_range(0, 10) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        return op;
    endfunction

    function automatic alu_op_t op_of(input ciau_pkg::cmd_t c, input logic [3:0] at,
                                      input logic [63:0] av, input logic [3:0] bt,
                                      input logic [63:0] bv);
        alu_op_t op;
        op = '0;
        op.cmd = c; op.a_type = at; op.a_value = av; op.b_type = bt; op.b_value = bv;
        return op;
    endfunction

    initial begin
        alu_op_t op;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: overflow, min times -1, zero divide, min/-1, shifts, types, poison
        send_op(op_of(ciau_pkg::CMD_ADD, 4'd5, 64'h7FFFFFFF, 4'd5, 64'd1));
        send_op(op_of(ciau_pkg::CMD_SUB, 4'd7, 64'h8000_0000_0000_0000, 4'd7, 64'd1));
        send_op(op_of(ciau_pkg::CMD_MUL, 4'd1, 64'h80, 4'd1, 64'hFF));
        send_op(op_of(ciau_pkg::CMD_MUL, 4'd7, 64'h1_0000_0000, 4'd7, 64'h1_0000_0000));
        send_op(op_of(ciau_pkg::CMD_MUL, 4'd8, {64{1'b1}}, 4'd8, {64{1'b1}}));
        send_op(op_of(ciau_pkg::CMD_DIV, 4'd3, 64'h1234, 4'd3, 64'd0));
        send_op(op_of(ciau_pkg::CMD_MOD, 4'd7, 64'h8000_0000_0000_0000, 4'd7, {64{1'b1}}));
        send_op(op_of(ciau_pkg::CMD_DIV, 4'd5, 64'hFFFFFFFF, 4'd5, 64'h80000000));
        send_op(op_of(ciau_pkg::CMD_DIV, 4'd7, 64'hFFFF_FFFF_FFFF_FFF9, 4'd7, 64'd2));
        send_op(op_of(ciau_pkg::CMD_MOD, 4'd8, {64{1'b1}}, 4'd8, 64'd7));
        send_op(op_of(ciau_pkg::CMD_NEG, 4'd1, 64'h80, 4'd0, 64'd0));
        send_op(op_of(ciau_pkg::CMD_SHL, 4'd5, 64'd1, 4'd1, 64'hFF));
        send_op(op_of(ciau_pkg::CMD_SHL, 4'd0, 64'd1, 4'd2, 64'd8));
        send_op(op_of(ciau_pkg::CMD_SHL, 4'd5, 64'd1, 4'd6, 64'd31));
        send_op(op_of(ciau_pkg::CMD_SHR, 4'd3, 64'h8000, 4'd2, 64'd1));
        send_op(op_of(ciau_pkg::CMD_LNOT, 4'd2, 64'd0, 4'd0, 64'd0));
        send_op(op_of(ciau_pkg::CMD_LAND, 4'd2, 64'd1, 4'd2, 64'd1));
        send_op(op_of(ciau_pkg::CMD_ADD, 4'd2, 64'd1, 4'd4, 64'd1));
        send_op(op_of(ciau_pkg::CMD_BNOT, 4'd0, 64'd1, 4'd0, 64'd0));
        send_op(op_of(ciau_pkg::CMD_CAST, 4'd7, {64{1'b1}}, 4'd0, 64'd0));
        op = op_of(ciau_pkg::CMD_PLUS, 4'd6, 64'd5, 4'd15, 64'd0); op.a_ub = 4'd7; send_op(op);
        op = op_of(ciau_pkg::CMD_PLUS, 4'd6, 64'd5, 4'd0, 64'd0); op.a_ub = 4'd12; send_op(op);
        op = op_of(ciau_pkg::CMD_SHR, 4'd2, 64'd5, 4'd2, 64'd9); op.b_ub = 4'd3; send_op(op);
        send_op(op_of(ciau_pkg::cmd_t'(5'd31), 4'd1, 64'd0, 4'd1, 64'd0));
        send_op(op_of(ciau_pkg::CMD_XOR, 4'd15, {64{1'b1}}, 4'd15, {64{1'b1}}));

        // random phases over both shift rules, the sender holding off once
        for (int ph = 0; ph < 4; ph++) begin
            write_lang(ph[0]);
            for (int i = 0; i < 100; i++) begin
                if (ph == 3 && i >= 70) quiet = 1'b1;
                send_op(rand_op());
                if (ph == 1 && i == 50) wait_drain();
            end
        end

        wait_drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== checked_integer_alu_ub_detect_core.f =====
design/ciau_pkg.sv
design/ciau_unit.sv
design/checked_integer_alu_ub_detect_core.sv
tb/tb_checked_integer_alu_ub_detect_core.sv
